FILE: src/qvr_pkg.sv
// Shared constants for the quaternion vector rotator.
package qvr_pkg;

  localparam int COMP_W    = 16;
  localparam int LANES     = 3;
  localparam int PROD_W    = 2 * COMP_W;
  localparam int SUM_W     = PROD_W + 2;
  localparam int CROSS_W   = PROD_W + 1;
  localparam int NRM_W     = PROD_W + 1;
  localparam int MUL_W     = SUM_W + COMP_W;
  localparam int NUM_W     = MUL_W + 2;
  localparam int DIV_STEPS = COMP_W;

  localparam logic signed [COMP_W-1:0] SAT_MAX = {1'b0, {(COMP_W-1){1'b1}}};
  localparam logic signed [COMP_W-1:0] SAT_MIN = {1'b1, {(COMP_W-1){1'b0}}};

endpackage

FILE: src/quaternion_vector_rotator_unit.sv
// Pipelined rotation of a vector by a quaternion with exact division by the norm.
//
//  Channel  Direction  Ports                                    Handshake
//  in       input      in_quat_w/x/y/z, in_vec_x/y/z            in_valid, in_stall
//  out      output     out_rot_x/y/z, out_zero_quat, out_clipped out_valid, out_stall
//
// One word is accepted per cycle while a finished word is not stalled.
// Four arithmetic stages feed 17 division stages, which resolve one quotient bit in each
// of the last 16, and a final saturation register.
// The whole pipeline advances together and holds while a finished word is stalled.
// Reset is synchronous and clears the valid bits only.
module quaternion_vector_rotator_unit
  import qvr_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [COMP_W-1:0] in_quat_w,
  input  logic signed [COMP_W-1:0] in_quat_x,
  input  logic signed [COMP_W-1:0] in_quat_y,
  input  logic signed [COMP_W-1:0] in_quat_z,
  input  logic signed [COMP_W-1:0] in_vec_x,
  input  logic signed [COMP_W-1:0] in_vec_y,
  input  logic signed [COMP_W-1:0] in_vec_z,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [COMP_W-1:0] out_rot_x,
  output logic signed [COMP_W-1:0] out_rot_y,
  output logic signed [COMP_W-1:0] out_rot_z,
  output logic                     out_zero_quat,
  output logic                     out_clipped
);

  logic en;

  logic v1_r, v2_r, v3_r, v4_r, out_valid_r;
  logic dv_r [DIV_STEPS+1];

  logic signed [COMP_W-1:0]  w1_r, x1_r, y1_r, z1_r;
  logic signed [PROD_W-1:0]  ww1_r, xx1_r, yy1_r, zz1_r;
  logic signed [PROD_W-1:0]  xvx1_r, yvy1_r, zvz1_r;
  logic signed [PROD_W-1:0]  yvz1_r, zvy1_r, zvx1_r, xvz1_r, xvy1_r, yvx1_r;
  logic signed [COMP_W-1:0]  vec1_r [LANES];

  logic signed [COMP_W-1:0]  w2_r;
  logic signed [COMP_W-1:0]  u2_r [LANES];
  logic signed [COMP_W-1:0]  vec2_r [LANES];
  logic signed [SUM_W-1:0]   s2_r, d2_r;
  logic signed [CROSS_W-1:0] c2_r [LANES];
  logic [NRM_W-1:0]          n2_r;

  logic signed [MUL_W-1:0]   pa3_r [LANES];
  logic signed [MUL_W-1:0]   pb3_r [LANES];
  logic signed [MUL_W-1:0]   pc3_r [LANES];
  logic [NRM_W-1:0]          n3_r;

  logic signed [NUM_W-1:0]   num4_r [LANES];
  logic [NRM_W-1:0]          n4_r;

  logic [NUM_W-1:0]          rem_r [DIV_STEPS][LANES];
  logic [COMP_W-1:0]         quo_r [DIV_STEPS+1][LANES];
  logic                      neg_r [DIV_STEPS+1][LANES];
  logic                      ovf_r [DIV_STEPS+1][LANES];
  logic [NRM_W-1:0]          nrm_r [DIV_STEPS+1];
  logic                      zq_r  [DIV_STEPS+1];

  logic signed [SUM_W-1:0]   uu2_nxt;
  logic signed [NUM_W-1:0]   num4_nxt [LANES];
  logic [NUM_W-1:0]          mag_nxt  [LANES];
  logic [NUM_W-1:0]          rem_nxt  [DIV_STEPS][LANES];
  logic [COMP_W-1:0]         quo_nxt  [DIV_STEPS][LANES];
  logic signed [COMP_W-1:0]  rot_nxt  [LANES];
  logic                      clip_nxt;

  logic signed [COMP_W-1:0]  rot_r [LANES];
  logic                      zero_quat_r, clipped_r;

  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;

  always_comb begin
    uu2_nxt = SUM_W'(xx1_r) + SUM_W'(yy1_r) + SUM_W'(zz1_r);
  end

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      num4_nxt[l] = NUM_W'(pa3_r[l]) + (NUM_W'(pb3_r[l]) <<< 1) + (NUM_W'(pc3_r[l]) <<< 1);
      mag_nxt[l]  = num4_r[l][NUM_W-1] ? NUM_W'(-num4_r[l]) : NUM_W'(num4_r[l]);
    end
  end

  always_comb begin
    for (int k = 0; k < DIV_STEPS; k++) begin
      for (int l = 0; l < LANES; l++) begin
        logic [NUM_W-1:0] sub;
        sub = NUM_W'(nrm_r[k]) << (DIV_STEPS - 1 - k);
        rem_nxt[k][l] = rem_r[k][l];
        quo_nxt[k][l] = quo_r[k][l];
        if (rem_r[k][l] >= sub) begin
          rem_nxt[k][l] = rem_r[k][l] - sub;
          quo_nxt[k][l][DIV_STEPS-1-k] = 1'b1;
        end
      end
    end
  end

  always_comb begin
    clip_nxt = 1'b0;
    for (int l = 0; l < LANES; l++) begin
      if (zq_r[DIV_STEPS]) begin
        rot_nxt[l] = '0;
      end else if (neg_r[DIV_STEPS][l]) begin
        if (ovf_r[DIV_STEPS][l] || quo_r[DIV_STEPS][l] > COMP_W'(SAT_MIN)) begin
          rot_nxt[l] = SAT_MIN;
          clip_nxt   = 1'b1;
        end else begin
          rot_nxt[l] = -$signed(quo_r[DIV_STEPS][l]);
        end
      end else begin
        if (ovf_r[DIV_STEPS][l] || quo_r[DIV_STEPS][l] > COMP_W'(SAT_MAX)) begin
          rot_nxt[l] = SAT_MAX;
          clip_nxt   = 1'b1;
        end else begin
          rot_nxt[l] = $signed(quo_r[DIV_STEPS][l]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
      for (int k = 0; k <= DIV_STEPS; k++) begin
        dv_r[k] <= 1'b0;
      end
    end else if (en) begin
      v1_r    <= in_valid;
      v2_r    <= v1_r;
      v3_r    <= v2_r;
      v4_r    <= v3_r;
      dv_r[0] <= v4_r;
      for (int k = 0; k < DIV_STEPS; k++) begin
        dv_r[k+1] <= dv_r[k];
      end
      out_valid_r <= dv_r[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      w1_r      <= in_quat_w;
      x1_r      <= in_quat_x;
      y1_r      <= in_quat_y;
      z1_r      <= in_quat_z;
      vec1_r[0] <= in_vec_x;
      vec1_r[1] <= in_vec_y;
      vec1_r[2] <= in_vec_z;
      ww1_r     <= in_quat_w * in_quat_w;
      xx1_r     <= in_quat_x * in_quat_x;
      yy1_r     <= in_quat_y * in_quat_y;
      zz1_r     <= in_quat_z * in_quat_z;
      xvx1_r    <= in_quat_x * in_vec_x;
      yvy1_r    <= in_quat_y * in_vec_y;
      zvz1_r    <= in_quat_z * in_vec_z;
      yvz1_r    <= in_quat_y * in_vec_z;
      zvy1_r    <= in_quat_z * in_vec_y;
      zvx1_r    <= in_quat_z * in_vec_x;
      xvz1_r    <= in_quat_x * in_vec_z;
      xvy1_r    <= in_quat_x * in_vec_y;
      yvx1_r    <= in_quat_y * in_vec_x;

      w2_r    <= w1_r;
      u2_r[0] <= x1_r;
      u2_r[1] <= y1_r;
      u2_r[2] <= z1_r;
      for (int l = 0; l < LANES; l++) begin
        vec2_r[l] <= vec1_r[l];
      end
      s2_r    <= SUM_W'(ww1_r) - uu2_nxt;
      n2_r    <= NRM_W'(SUM_W'(ww1_r) + uu2_nxt);
      d2_r    <= SUM_W'(xvx1_r) + SUM_W'(yvy1_r) + SUM_W'(zvz1_r);
      c2_r[0] <= CROSS_W'(yvz1_r) - CROSS_W'(zvy1_r);
      c2_r[1] <= CROSS_W'(zvx1_r) - CROSS_W'(xvz1_r);
      c2_r[2] <= CROSS_W'(xvy1_r) - CROSS_W'(yvx1_r);

      n3_r <= n2_r;
      for (int l = 0; l < LANES; l++) begin
        pa3_r[l] <= s2_r * vec2_r[l];
        pb3_r[l] <= d2_r * u2_r[l];
        pc3_r[l] <= c2_r[l] * w2_r;
      end

      n4_r <= n3_r;
      for (int l = 0; l < LANES; l++) begin
        num4_r[l] <= num4_nxt[l];
      end

      nrm_r[0] <= n4_r;
      zq_r[0]  <= (n4_r == '0);
      for (int l = 0; l < LANES; l++) begin
        rem_r[0][l] <= mag_nxt[l];
        quo_r[0][l] <= '0;
        neg_r[0][l] <= num4_r[l][NUM_W-1];
        ovf_r[0][l] <= (mag_nxt[l] >= (NUM_W'(n4_r) << DIV_STEPS));
      end

      for (int k = 0; k < DIV_STEPS; k++) begin
        nrm_r[k+1] <= nrm_r[k];
        zq_r[k+1]  <= zq_r[k];
        for (int l = 0; l < LANES; l++) begin
          quo_r[k+1][l] <= quo_nxt[k][l];
          neg_r[k+1][l] <= neg_r[k][l];
          ovf_r[k+1][l] <= ovf_r[k][l];
        end
      end

      for (int k = 0; k < DIV_STEPS - 1; k++) begin
        for (int l = 0; l < LANES; l++) begin
          rem_r[k+1][l] <= rem_nxt[k][l];
        end
      end

      for (int l = 0; l < LANES; l++) begin
        rot_r[l] <= rot_nxt[l];
      end
      zero_quat_r <= zq_r[DIV_STEPS];
      clipped_r   <= clip_nxt && !zq_r[DIV_STEPS];
    end
  end

  assign out_valid     = out_valid_r;
  assign out_rot_x     = rot_r[0];
  assign out_rot_y     = rot_r[1];
  assign out_rot_z     = rot_r[2];
  assign out_zero_quat = zero_quat_r;
  assign out_clipped   = clipped_r;

endmodule

FILE: bench/tb_quaternion_vector_rotator_unit.sv
// Testbench for the quaternion vector rotator: directed table plus random words against a predictor.
`timescale 1ns / 1ps

module tb_quaternion_vector_rotator_unit;
  import qvr_pkg::*;

  typedef logic signed [COMP_W-1:0] comp_t;

  typedef struct {
    comp_t w, x, y, z, vx, vy, vz;
  } rot_in_t;

  typedef struct packed {
    comp_t rx, ry, rz;
    logic  zq, cl;
  } rot_out_t;

  typedef struct {
    rot_in_t  word;
    logic     typed;
    rot_out_t res;
  } table_row_t;

  localparam int RANDOM_WORDS = 700;
  localparam int LATENCY      = 22;
  localparam longint CYCLE_LIMIT = 400000;

  logic  clk;
  logic  rst_n;
  logic  in_valid;
  logic  in_stall;
  comp_t in_quat_w, in_quat_x, in_quat_y, in_quat_z;
  comp_t in_vec_x, in_vec_y, in_vec_z;
  logic  out_valid;
  logic  out_stall;
  comp_t out_rot_x, out_rot_y, out_rot_z;
  logic  out_zero_quat;
  logic  out_clipped;

  rot_out_t   rotated_q[$];
  table_row_t directed_rows[$];
  int         fail_count;
  longint     cycle_count;

  quaternion_vector_rotator_unit uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_quat_w(in_quat_w), .in_quat_x(in_quat_x),
    .in_quat_y(in_quat_y), .in_quat_z(in_quat_z),
    .in_vec_x(in_vec_x), .in_vec_y(in_vec_y), .in_vec_z(in_vec_z),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_rot_x(out_rot_x), .out_rot_y(out_rot_y), .out_rot_z(out_rot_z),
    .out_zero_quat(out_zero_quat), .out_clipped(out_clipped)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic comp_t clamp_comp(input longint v, inout logic sat);
    if (v > 32767) begin
      sat = 1'b1;
      return SAT_MAX;
    end else if (v < -32768) begin
      sat = 1'b1;
      return SAT_MIN;
    end
    return comp_t'(v);
  endfunction

  function automatic rot_out_t rotate_vector(input rot_in_t a);
    longint w, x, y, z, vx, vy, vz, uu, n, s, d, cx, cy, cz, nx, ny, nz;
    rot_out_t r;
    logic sat;
    w = a.w; x = a.x; y = a.y; z = a.z;
    vx = a.vx; vy = a.vy; vz = a.vz;
    sat = 1'b0;
    uu = x * x + y * y + z * z;
    n = w * w + uu;
    if (n == 0) begin
      r.rx = '0; r.ry = '0; r.rz = '0; r.zq = 1'b1; r.cl = 1'b0;
      return r;
    end
    s = w * w - uu;
    d = x * vx + y * vy + z * vz;
    cx = y * vz - z * vy;
    cy = z * vx - x * vz;
    cz = x * vy - y * vx;
    nx = s * vx + 2 * d * x + 2 * w * cx;
    ny = s * vy + 2 * d * y + 2 * w * cy;
    nz = s * vz + 2 * d * z + 2 * w * cz;
    r.rx = clamp_comp(nx / n, sat);
    r.ry = clamp_comp(ny / n, sat);
    r.rz = clamp_comp(nz / n, sat);
    r.zq = 1'b0;
    r.cl = sat;
    return r;
  endfunction

  function automatic comp_t rand_comp();
    unique case ($urandom_range(0, 7))
      0: return SAT_MAX;
      1: return SAT_MIN;
      2: return comp_t'($urandom_range(0, 4) - 2);
      default: return comp_t'($urandom);
    endcase
  endfunction

  // Mostly unit quaternions near Q2.14 one, with random vectors; the rest is raw noise.
  function automatic rot_in_t rand_word();
    rot_in_t a;
    real th, ux, uy, uz, m;
    if ($urandom_range(0, 3) != 0) begin
      th = ($urandom_range(0, 62831) / 10000.0);
      ux = $urandom_range(0, 2000) - 1000.0;
      uy = $urandom_range(0, 2000) - 1000.0;
      uz = $urandom_range(0, 2000) - 1000.0;
      m = $sqrt(ux * ux + uy * uy + uz * uz) + 1.0;
      a.w = comp_t'($rtoi(16384.0 * $cos(th / 2)));
      a.x = comp_t'($rtoi(16384.0 * $sin(th / 2) * ux / m));
      a.y = comp_t'($rtoi(16384.0 * $sin(th / 2) * uy / m));
      a.z = comp_t'($rtoi(16384.0 * $sin(th / 2) * uz / m));
    end else begin
      a.w = rand_comp(); a.x = rand_comp(); a.y = rand_comp(); a.z = rand_comp();
    end
    a.vx = rand_comp(); a.vy = rand_comp(); a.vz = rand_comp();
    return a;
  endfunction

  function automatic table_row_t mk_row(input comp_t w, x, y, z, vx, vy, vz, input logic typed,
                                        input comp_t rx, ry, rz, input logic zq, cl);
    table_row_t t;
    t.word = '{w, x, y, z, vx, vy, vz};
    t.typed = typed;
    t.res = '{rx, ry, rz, zq, cl};
    return t;
  endfunction

  task automatic send_word(input rot_in_t a);
    in_valid  <= 1'b1;
    in_quat_w <= a.w; in_quat_x <= a.x; in_quat_y <= a.y; in_quat_z <= a.z;
    in_vec_x  <= a.vx; in_vec_y <= a.vy; in_vec_z <= a.vz;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic pause_sender(inout int burst_left);
    int gap;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    burst_left = $urandom_range(0, 20);
    gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Accepted input words are predicted at the same edge they are taken.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      rotated_q.push_back(rotate_vector('{in_quat_w, in_quat_x, in_quat_y, in_quat_z,
                                         in_vec_x, in_vec_y, in_vec_z}));
    end
  end

  always @(posedge clk) begin
    rot_out_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (rotated_q.size() == 0) begin
        $error("result word with no expectation pending");
        fail_count++;
      end else begin
        e = rotated_q.pop_front();
        if (out_rot_x !== e.rx) begin
          $error("rot_x expected %0d actual %0d", e.rx, out_rot_x); fail_count++;
        end
        if (out_rot_y !== e.ry) begin
          $error("rot_y expected %0d actual %0d", e.ry, out_rot_y); fail_count++;
        end
        if (out_rot_z !== e.rz) begin
          $error("rot_z expected %0d actual %0d", e.rz, out_rot_z); fail_count++;
        end
        if (out_zero_quat !== e.zq) begin
          $error("zero_quat expected %0b actual %0b", e.zq, out_zero_quat); fail_count++;
        end
        if (out_clipped !== e.cl) begin
          $error("clipped expected %0b actual %0b", e.cl, out_clipped); fail_count++;
        end
      end
    end
  end

  // The receiver alternates between free-running stretches and random stalling.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if ((cycle_count / 200) % 3 == 0) begin
      out_stall <= 1'b0;
    end else if ((cycle_count / 200) % 3 == 1) begin
      out_stall <= ($urandom_range(0, 3) == 0);
    end else begin
      out_stall <= ($urandom_range(0, 1) == 0);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    rot_out_t got;
    int burst_left;
    fail_count  = 0;
    cycle_count = 0;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_quat_w = '0; in_quat_x = '0; in_quat_y = '0; in_quat_z = '0;
    in_vec_x  = '0; in_vec_y  = '0; in_vec_z  = '0;
    out_stall = 1'b0;
    burst_left = 0;

    // Zero quaternion, identity, its sign flips, half-turns, a quarter-turn and saturating cases.
    directed_rows.push_back(mk_row(0, 0, 0, 0, 100, -200, 300, 1, 0, 0, 0, 1, 0));
    directed_rows.push_back(mk_row(0, 0, 0, 0, SAT_MIN, SAT_MAX, SAT_MIN, 1, 0, 0, 0, 1, 0));
    directed_rows.push_back(mk_row(16384, 0, 0, 0, 1234, -5678, 42, 1, 1234, -5678, 42, 0, 0));
    directed_rows.push_back(mk_row(SAT_MIN, 0, 0, 0, SAT_MAX, SAT_MIN, -1, 1,
                                   SAT_MAX, SAT_MIN, -1, 0, 0));
    directed_rows.push_back(mk_row(1, 0, 0, 0, SAT_MIN, SAT_MAX, 0, 1, SAT_MIN, SAT_MAX, 0, 0, 0));
    directed_rows.push_back(mk_row(0, 16384, 0, 0, 7, 9, 11, 1, 7, -9, -11, 0, 0));
    directed_rows.push_back(mk_row(0, 0, 16384, 0, SAT_MIN, 5, SAT_MIN, 1,
                                   SAT_MAX, 5, SAT_MAX, 0, 1));
    directed_rows.push_back(mk_row(0, 0, 0, SAT_MAX, 3, -4, 5, 1, -3, 4, 5, 0, 0));
    directed_rows.push_back(mk_row(11585, 0, 0, 11585, 1000, 0, 0, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(mk_row(SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX,
                                   SAT_MAX, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(mk_row(SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN,
                                   SAT_MIN, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(mk_row(SAT_MAX, SAT_MIN, 1, -1, SAT_MIN, SAT_MAX, SAT_MIN,
                                   0, 0, 0, 0, 0, 0));
    directed_rows.push_back(mk_row(1, 1, -1, 1, SAT_MAX, SAT_MIN, SAT_MAX, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(mk_row(-1, 0, 0, 0, -1, -1, -1, 1, -1, -1, -1, 0, 0));

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      got = rotate_vector(directed_rows[i].word);
      if (directed_rows[i].typed && got != directed_rows[i].res) begin
        $error("table row %0d disagrees with its typed result", i);
        fail_count++;
      end
      send_word(directed_rows[i].word);
      pause_sender(burst_left);
    end

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      send_word(rand_word());
      pause_sender(burst_left);
    end
    in_valid <= 1'b0;

    while (rotated_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
